/* hdl/qfc_pkg.sv */
// shared codes and types for the quadratic frobenius core
// datapath op codes, register selects, command and status structs; no dependencies
package qfc_pkg;

   localparam int MOD_WIDTH = 32;

   // datapath operations
   localparam logic [4:0] OP_NOP    = 5'd0;
   localparam logic [4:0] OP_LOAD   = 5'd1;
   localparam logic [4:0] OP_WR     = 5'd2;
   localparam logic [4:0] OP_WRJ    = 5'd3;
   localparam logic [4:0] OP_MOV    = 5'd4;
   localparam logic [4:0] OP_HADD   = 5'd5;
   localparam logic [4:0] OP_HSUB   = 5'd6;
   localparam logic [4:0] OP_ADDM   = 5'd7;
   localparam logic [4:0] OP_ADDDBL = 5'd8;
   localparam logic [4:0] OP_AFIX   = 5'd9;
   localparam logic [4:0] OP_DBL    = 5'd10;
   localparam logic [4:0] OP_XINIT  = 5'd11;
   localparam logic [4:0] OP_EXPH   = 5'd12;
   localparam logic [4:0] OP_NORM   = 5'd13;
   localparam logic [4:0] OP_SQRN   = 5'd14;
   localparam logic [4:0] OP_DECE   = 5'd15;
   localparam logic [4:0] OP_STRIP  = 5'd16;
   localparam logic [4:0] OP_RDEC   = 5'd17;

   // register selects
   localparam logic [3:0] R_A   = 4'd0;
   localparam logic [3:0] R_BJ  = 4'd1;
   localparam logic [3:0] R_CJ  = 4'd2;
   localparam logic [3:0] R_B   = 4'd3;
   localparam logic [3:0] R_C   = 4'd4;
   localparam logic [3:0] R_D   = 4'd5;
   localparam logic [3:0] R_T1  = 4'd6;
   localparam logic [3:0] R_T2  = 4'd7;
   localparam logic [3:0] R_T3  = 4'd8;
   localparam logic [3:0] R_ONE = 4'd9;

   // failing step codes
   localparam logic [1:0] STEP_NONE   = 2'd0;
   localparam logic [1:0] STEP_DEGREE = 2'd1;
   localparam logic [1:0] STEP_NORM   = 2'd2;
   localparam logic [1:0] STEP_SQUARE = 2'd3;

   typedef struct packed {
      logic [4:0] op;
      logic [3:0] dst;
      logic [3:0] src;
      logic       mul_go;
      logic [3:0] mul_a;
      logic [3:0] mul_b;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic e_top;
      logic e_lsb;
      logic cnt_zero;
      logic r_cap;
      logic r_gt1;
      logic fx_zero;
      logic a_one;
      logic a_nm1;
      logic norm_ok;
      logic bad_mod;
   } stat_type;

endpackage

/* hdl/qfc_mul.sv */
// bit-serial modular multiplier, one multiplier bit per cycle
// depends on qfc_pkg
module qfc_mul #(
   parameter int W = qfc_pkg::MOD_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic [W-1:0] opa,
   input  logic [W-1:0] opb,
   input  logic [W-1:0] modulus,
   output logic [W-1:0] prod,
   output logic         done
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  acc_ff, acc_in, a_ff, b_ff;
   logic [CW-1:0] cnt_ff;
   logic          run_ff, done_ff;
   logic [W+1:0]  sum, twon, onen;

   // horner step: acc = 2*acc + bit*b, reduced below n (opb is below n)
   always_comb begin
      twon = {1'b0, modulus, 1'b0};
      onen = {2'b00, modulus};
      sum  = {1'b0, acc_ff, 1'b0} + (a_ff[W-1] ? {2'b00, b_ff} : '0);
      if (sum >= twon) begin
         sum = sum - twon;
      end else if (sum >= onen) begin
         sum = sum - onen;
      end
      acc_in = sum[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && (cnt_ff == CW'(1));
         if (go) begin
            run_ff <= 1'b1;
         end else if (run_ff && (cnt_ff == CW'(1))) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         acc_ff <= '0;
         a_ff   <= opa;
         b_ff   <= opb;
         cnt_ff <= CW'(W);
      end else if (run_ff) begin
         acc_ff <= acc_in;
         a_ff   <= {a_ff[W-2:0], 1'b0};
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   assign prod = acc_ff;
   assign done = done_ff;

endmodule

/* hdl/qfc_datapath.sv */
// datapath: operand registers, exponent shifter and modular add/halve logic
// depends on qfc_pkg and qfc_mul
module qfc_datapath #(
   parameter int W = qfc_pkg::MOD_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  qfc_pkg::cmd_type  cmd,
   input  logic [W-1:0]      in_modulus,
   input  logic [W-1:0]      in_param_b,
   input  logic [W-1:0]      in_param_c,
   input  logic [W-1:0]      in_discriminant,
   output qfc_pkg::stat_type stat
);
   localparam int EW  = 2 * W;
   localparam int ECW = $clog2(EW + 1);
   localparam int RW  = $clog2(EW);

   logic [W-1:0]   n_ff, b_ff, c_ff, d_ff, a_ff, bj_ff, cj_ff, t1_ff, t2_ff, t3_ff;
   logic [W-1:0]   n_in, b_in, c_in, d_in, a_in, bj_in, cj_in, t1_in, t2_in, t3_in;
   logic [EW-1:0]  e_ff, e_in, sq;
   logic [ECW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0]  r_ff, r_in;
   logic           jodd_ff, jodd_in;
   logic [W-1:0]   prod, srcv, mula, mulb, wv, normref;
   logic [W:0]     half_n;
   logic           wr_en, mul_done;

   function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] n);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, n}) begin
         s = s - {1'b0, n};
      end
      return s[W-1:0];
   endfunction

   function automatic logic [W-1:0] subm(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] n);
      logic [W:0] s;
      if (x >= y) begin
         s = {1'b0, x} - {1'b0, y};
      end else begin
         s = {1'b0, x} + {1'b0, n} - {1'b0, y};
      end
      return s[W-1:0];
   endfunction

   // v below 2n: reduce, make even by adding n, halve
   function automatic logic [W-1:0] halfm(input logic [W:0] v, input logic [W-1:0] n);
      logic [W:0] u;
      u = (v >= {1'b0, n}) ? v - {1'b0, n} : v;
      if (u[0]) begin
         u = u + {1'b0, n};
      end
      return u[W:1];
   endfunction

   function automatic logic [W-1:0] sel(input logic [3:0] code, input logic [W-1:0] ra,
                                        input logic [W-1:0] rbj, input logic [W-1:0] rcj,
                                        input logic [W-1:0] rb, input logic [W-1:0] rc,
                                        input logic [W-1:0] rd, input logic [W-1:0] rt1,
                                        input logic [W-1:0] rt2, input logic [W-1:0] rt3);
      logic [W-1:0] v;
      case (code)
         qfc_pkg::R_A:   v = ra;
         qfc_pkg::R_BJ:  v = rbj;
         qfc_pkg::R_CJ:  v = rcj;
         qfc_pkg::R_B:   v = rb;
         qfc_pkg::R_C:   v = rc;
         qfc_pkg::R_D:   v = rd;
         qfc_pkg::R_T1:  v = rt1;
         qfc_pkg::R_T2:  v = rt2;
         qfc_pkg::R_T3:  v = rt3;
         qfc_pkg::R_ONE: v = W'(1);
         default:        v = '0;
      endcase
      return v;
   endfunction

   assign srcv = sel(cmd.src, a_ff, bj_ff, cj_ff, b_ff, c_ff, d_ff, t1_ff, t2_ff, t3_ff);
   assign mula = sel(cmd.mul_a, a_ff, bj_ff, cj_ff, b_ff, c_ff, d_ff, t1_ff, t2_ff, t3_ff);
   assign mulb = sel(cmd.mul_b, a_ff, bj_ff, cj_ff, b_ff, c_ff, d_ff, t1_ff, t2_ff, t3_ff);
   assign sq   = n_ff * n_ff;
   assign half_n = {1'b0, n_ff} + (W+1)'(1);

   qfc_mul #(.W(W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .go      (cmd.mul_go),
      .opa     (mula),
      .opb     (mulb),
      .modulus (n_ff),
      .prod    (prod),
      .done    (mul_done)
   );

   // result of the generic register-write operations
   always_comb begin
      wr_en = 1'b1;
      case (cmd.op)
         qfc_pkg::OP_WR:     wv = prod;
         qfc_pkg::OP_WRJ:    wv = prod;
         qfc_pkg::OP_MOV:    wv = srcv;
         qfc_pkg::OP_HADD:   wv = halfm({1'b0, prod} + {1'b0, srcv}, n_ff);
         qfc_pkg::OP_HSUB:   wv = halfm({1'b0, srcv} + {1'b0, n_ff} - {1'b0, prod}, n_ff);
         qfc_pkg::OP_ADDM:   wv = addm(prod, srcv, n_ff);
         qfc_pkg::OP_ADDDBL: wv = addm(prod, addm(srcv, srcv, n_ff), n_ff);
         qfc_pkg::OP_AFIX:   wv = jodd_ff ? addm(prod, t1_ff, n_ff) : subm(prod, t1_ff, n_ff);
         qfc_pkg::OP_DBL:    wv = addm(srcv, srcv, n_ff);
         default: begin
            wv    = '0;
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      n_in    = n_ff;
      b_in    = (wr_en && cmd.dst == qfc_pkg::R_B)  ? wv : b_ff;
      c_in    = (wr_en && cmd.dst == qfc_pkg::R_C)  ? wv : c_ff;
      d_in    = (wr_en && cmd.dst == qfc_pkg::R_D)  ? wv : d_ff;
      a_in    = (wr_en && cmd.dst == qfc_pkg::R_A)  ? wv : a_ff;
      bj_in   = (wr_en && cmd.dst == qfc_pkg::R_BJ) ? wv : bj_ff;
      cj_in   = (wr_en && cmd.dst == qfc_pkg::R_CJ) ? wv : cj_ff;
      t1_in   = (wr_en && cmd.dst == qfc_pkg::R_T1) ? wv : t1_ff;
      t2_in   = (wr_en && cmd.dst == qfc_pkg::R_T2) ? wv : t2_ff;
      t3_in   = (wr_en && cmd.dst == qfc_pkg::R_T3) ? wv : t3_ff;
      e_in    = e_ff;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      jodd_in = jodd_ff;
      case (cmd.op)
         qfc_pkg::OP_LOAD: begin
            n_in = in_modulus;
            b_in = in_param_b;
            c_in = in_param_c;
            d_in = in_discriminant;
         end
         qfc_pkg::OP_XINIT: begin
            a_in    = b_ff;
            bj_in   = W'(1);
            cj_in   = c_ff;
            jodd_in = 1'b1;
            cnt_in  = ECW'(EW);
         end
         qfc_pkg::OP_EXPH:  e_in = {{W{1'b0}}, half_n[W:1]};
         qfc_pkg::OP_NORM: begin
            e_in   = {e_ff[EW-2:0], 1'b0};
            cnt_in = cnt_ff - ECW'(1);
         end
         qfc_pkg::OP_SQRN: begin
            e_in = sq;
            r_in = '0;
         end
         qfc_pkg::OP_DECE:  e_in = e_ff - EW'(1);
         qfc_pkg::OP_STRIP: begin
            e_in = {1'b0, e_ff[EW-1:1]};
            r_in = r_ff + RW'(1);
         end
         qfc_pkg::OP_RDEC:  r_in = r_ff - RW'(1);
         qfc_pkg::OP_AFIX:  jodd_in = 1'b0;
         qfc_pkg::OP_WRJ:   jodd_in = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jodd_ff <= 1'b1;
      end else begin
         jodd_ff <= jodd_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      a_ff   <= a_in;
      bj_ff  <= bj_in;
      cj_ff  <= cj_in;
      t1_ff  <= t1_in;
      t2_ff  <= t2_in;
      t3_ff  <= t3_in;
      e_ff   <= e_in;
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
   end

   assign normref = (c_ff == '0) ? '0 : n_ff - c_ff;

   always_comb begin
      stat.mul_done = mul_done;
      stat.e_top    = e_ff[EW-1];
      stat.e_lsb    = e_ff[0];
      stat.cnt_zero = (cnt_ff == '0);
      stat.r_cap    = (r_ff == RW'(EW - 1));
      stat.r_gt1    = (r_ff > RW'(1));
      stat.fx_zero  = (bj_ff == '0);
      stat.a_one    = (a_ff == W'(1));
      stat.a_nm1    = (a_ff == n_ff - W'(1));
      stat.norm_ok  = (prod == normref);
      stat.bad_mod  = !n_ff[0] || (n_ff == W'(1));
   end

endmodule

/* hdl/qfc_ctrl.sv */
// controller: sequences the test steps and drives the result strobe
// depends on qfc_pkg
module qfc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  qfc_pkg::stat_type stat,
   output qfc_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              rsp_valid,
   output logic              rsp_verdict,
   output logic [1:0]        rsp_failed_step
);
   localparam logic [5:0] S_IDLE  = 6'd0;
   localparam logic [5:0] S_CHK   = 6'd1;
   localparam logic [5:0] S_RB    = 6'd2;
   localparam logic [5:0] S_RC    = 6'd3;
   localparam logic [5:0] S_RD    = 6'd4;
   localparam logic [5:0] S_XINIT = 6'd5;
   localparam logic [5:0] S_XNORM = 6'd6;
   localparam logic [5:0] S_XLOOP = 6'd7;
   localparam logic [5:0] S_D1    = 6'd8;
   localparam logic [5:0] S_D2    = 6'd9;
   localparam logic [5:0] S_D3    = 6'd10;
   localparam logic [5:0] S_A1    = 6'd11;
   localparam logic [5:0] S_A2    = 6'd12;
   localparam logic [5:0] S_A3    = 6'd13;
   localparam logic [5:0] S_A4    = 6'd14;
   localparam logic [5:0] S_A5    = 6'd15;
   localparam logic [5:0] S_XNEXT = 6'd16;
   localparam logic [5:0] S_XFIN  = 6'd17;
   localparam logic [5:0] S_S3    = 6'd18;
   localparam logic [5:0] S_S4    = 6'd19;
   localparam logic [5:0] S_SQ2   = 6'd20;
   localparam logic [5:0] S_STRIP = 6'd21;
   localparam logic [5:0] S_Q0    = 6'd22;
   localparam logic [5:0] S_Q1    = 6'd23;
   localparam logic [5:0] S_Q2    = 6'd24;
   localparam logic [5:0] S_Q3    = 6'd25;
   localparam logic [5:0] S_Q4    = 6'd26;
   localparam logic [5:0] S_Q5    = 6'd27;
   localparam logic [5:0] S_Q6    = 6'd28;
   localparam logic [5:0] S_QNX   = 6'd29;
   localparam logic [5:0] S_WAIT  = 6'd30;
   localparam logic [5:0] S_EXPH  = 6'd31;

   logic [5:0] state_ff, state_in, ret_ff, ret_in;
   logic       pass_ff, pass_in, rv_ff, rv_in, verd_ff, verd_in;
   logic [1:0] step_ff, step_in;

   always_comb begin
      cmd      = '0;
      cmd.op   = qfc_pkg::OP_NOP;
      state_in = state_ff;
      ret_in   = ret_ff;
      pass_in  = pass_ff;
      rv_in    = 1'b0;
      verd_in  = verd_ff;
      step_in  = step_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = qfc_pkg::OP_LOAD;
               pass_in  = 1'b0;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (stat.bad_mod) begin
               rv_in = 1'b1; verd_in = 1'b0; step_in = qfc_pkg::STEP_NONE;
               state_in = S_IDLE;
            end else begin
               cmd.mul_go = 1'b1; cmd.mul_a = qfc_pkg::R_B; cmd.mul_b = qfc_pkg::R_ONE;
               ret_in = S_RB; state_in = S_WAIT;
            end
         end
         S_RB: begin
            cmd.op = qfc_pkg::OP_WR; cmd.dst = qfc_pkg::R_B;
            cmd.mul_go = 1'b1; cmd.mul_a = qfc_pkg::R_C; cmd.mul_b = qfc_pkg::R_ONE;
            ret_in = S_RC; state_in = S_WAIT;
         end
         S_RC: begin
            cmd.op = qfc_pkg::OP_WR; cmd.dst = qfc_pkg::R_C;
            cmd.mul_go = 1'b1; cmd.mul_a = qfc_pkg::R_D; cmd.mul_b = qfc_pkg::R_ONE;
            ret_in = S_RD; state_in = S_WAIT;
         end
         S_RD: begin
            cmd.op = qfc_pkg::OP_WR; cmd.dst = qfc_pkg::R_D;
            state_in = S_EXPH;
         end
         S_EXPH: begin
            cmd.op = qfc_pkg::OP_EXPH;
            state_in = S_XINIT;
         end
         S_XINIT: begin
            cmd.op = qfc_pkg::OP_XINIT;
            state_in = S_XNORM;
         end
         S_XNORM: begin
            // shift out leading zeros, then the leading one itself
            cmd.op = qfc_pkg::OP_NORM;
            if (stat.e_top) begin
               state_in = S_XLOOP;
            end
         end
         S_XLOOP: begin
            cmd.mul_go = 1'b1;
            state_in   = S_WAIT;
            if (stat.cnt_zero) begin
               cmd.mul_a = qfc_pkg::R_B; cmd.mul_b = qfc_pkg::R_BJ;
               ret_in = S_XFIN;
            end else begin
               cmd.op = qfc_pkg::OP_DBL; cmd.dst = qfc_pkg::R_T1; cmd.src = qfc_pkg::R_CJ;
               cmd.mul_a = qfc_pkg::R_A; cmd.mul_b = qfc_pkg::R_BJ;
               ret_in = S_D1;
            end
         end
         S_D1: begin
            cmd.op = qfc_pkg::OP_WR; cmd.dst = qfc_pkg::R_BJ;
            cmd.mul_go = 1'b1; cmd.mul_a = qfc_pkg::R_A; cmd.mul_b = qfc_pkg::R_A;
            ret_in = S_D2; state_in = S_WAIT;
         end
         S_D2: begin
            cmd.op = qfc_pkg::OP_AFIX; cmd.dst = qfc_pkg::R_A;
            cmd.mul_go = 1'b1; cmd.mul_a = qfc_pkg::R_CJ; cmd.mul_b = qfc_pkg::R_CJ;
            ret_in = S_D3; state_in = S_WAIT;
         end
         S_D3: begin
            cmd.op = qfc_pkg::OP_WR; cmd.dst = qfc_pkg::R_CJ;
            if (stat.e_top) begin
               cmd.mul_go = 1'b1; cmd.mul_a = qfc_pkg::R_D; cmd.mul_b = qfc_pkg::R_BJ;
               ret_in = S_A1; state_in = S_WAIT;
            end else begin
               state_in = S_XNEXT;
            end
         end
         S_A1: begin
            cmd.op = qfc_pkg::OP_WR; cmd.dst = qfc_pkg::R_T2;
            cmd.mul_go = 1'b1; cmd.mul_a = qfc_pkg::R_B; cmd.mul_b = qfc_pkg::R_A;
            ret_in = S_A2; state_in = S_WAIT;
         end
         S_A2: begin
            cmd.op = qfc_pkg::OP_HADD; cmd.dst = qfc_pkg::R_T3; cmd.src = qfc_pkg::R_T2;
            cmd.mul_go = 1'b1; cmd.mul_a = qfc_pkg::R_B; cmd.mul_b = qfc_pkg::R_BJ;
            ret_in = S_A3; state_in = S_WAIT;
         end
         S_A3: begin
            cmd.op = qfc_pkg::OP_HADD; cmd.dst = qfc_pkg::R_BJ; cmd.src = qfc_pkg::R_A;
            cmd.mul_go = 1'b1; cmd.mul_a = qfc_pkg::R_CJ; cmd.mul_b = qfc_pkg::R_C;
            ret_in = S_A4; state_in = S_WAIT;
         end
         S_A4: begin
            cmd.op = qfc_pkg::OP_WRJ; cmd.dst = qfc_pkg::R_CJ;
            state_in = S_A5;
         end
         S_A5: begin
            cmd.op = qfc_pkg::OP_MOV; cmd.dst = qfc_pkg::R_A; cmd.src = qfc_pkg::R_T3;
            state_in = S_XNEXT;
         end
         S_XNEXT: begin
            cmd.op = qfc_pkg::OP_NORM;
            state_in = S_XLOOP;
         end
         S_XFIN: begin
            cmd.op = qfc_pkg::OP_HSUB; cmd.dst = qfc_pkg::R_A; cmd.src = qfc_pkg::R_A;
            state_in = pass_ff ? S_Q0 : S_S3;
         end
         S_S3: begin
            if (!stat.fx_zero) begin
               rv_in = 1'b1; verd_in = 1'b0; step_in = qfc_pkg::STEP_DEGREE;
               state_in = S_IDLE;
            end else begin
               cmd.mul_go = 1'b1; cmd.mul_a = qfc_pkg::R_A; cmd.mul_b = qfc_pkg::R_A;
               ret_in = S_S4; state_in = S_WAIT;
            end
         end
         S_S4: begin
            if (!stat.norm_ok) begin
               rv_in = 1'b1; verd_in = 1'b0; step_in = qfc_pkg::STEP_NORM;
               state_in = S_IDLE;
            end else begin
               cmd.op   = qfc_pkg::OP_SQRN;
               pass_in  = 1'b1;
               state_in = S_SQ2;
            end
         end
         S_SQ2: begin
            cmd.op = qfc_pkg::OP_DECE;
            state_in = S_STRIP;
         end
         S_STRIP: begin
            if (stat.e_lsb || stat.r_cap) begin
               state_in = S_XINIT;
            end else begin
               cmd.op = qfc_pkg::OP_STRIP;
            end
         end
         S_Q0: begin
            if (stat.fx_zero && stat.a_one) begin
               rv_in = 1'b1; verd_in = 1'b1; step_in = qfc_pkg::STEP_NONE;
               state_in = S_IDLE;
            end else begin
               state_in = S_Q1;
            end
         end
         S_Q1: begin
            if (!stat.r_gt1) begin
               rv_in = 1'b1; verd_in = 1'b0; step_in = qfc_pkg::STEP_SQUARE;
               state_in = S_IDLE;
            end else if (stat.fx_zero && stat.a_nm1) begin
               rv_in = 1'b1; verd_in = 1'b1; step_in = qfc_pkg::STEP_NONE;
               state_in = S_IDLE;
            end else begin
               cmd.mul_go = 1'b1; cmd.mul_a = qfc_pkg::R_A; cmd.mul_b = qfc_pkg::R_A;
               ret_in = S_Q2; state_in = S_WAIT;
            end
         end
         S_Q2: begin
            cmd.op = qfc_pkg::OP_WR;
            if (stat.fx_zero) begin
               cmd.dst  = qfc_pkg::R_A;
               state_in = S_QNX;
            end else begin
               cmd.dst = qfc_pkg::R_T1;
               cmd.mul_go = 1'b1; cmd.mul_a = qfc_pkg::R_BJ; cmd.mul_b = qfc_pkg::R_BJ;
               ret_in = S_Q3; state_in = S_WAIT;
            end
         end
         S_Q3: begin
            cmd.op = qfc_pkg::OP_WR; cmd.dst = qfc_pkg::R_T2;
            cmd.mul_go = 1'b1; cmd.mul_a = qfc_pkg::R_BJ; cmd.mul_b = qfc_pkg::R_A;
            ret_in = S_Q4; state_in = S_WAIT;
         end
         S_Q4: begin
            cmd.op = qfc_pkg::OP_WR; cmd.dst = qfc_pkg::R_T3;
            cmd.mul_go = 1'b1; cmd.mul_a = qfc_pkg::R_T2; cmd.mul_b = qfc_pkg::R_B;
            ret_in = S_Q5; state_in = S_WAIT;
         end
         S_Q5: begin
            cmd.op = qfc_pkg::OP_ADDDBL; cmd.dst = qfc_pkg::R_BJ; cmd.src = qfc_pkg::R_T3;
            cmd.mul_go = 1'b1; cmd.mul_a = qfc_pkg::R_T2; cmd.mul_b = qfc_pkg::R_C;
            ret_in = S_Q6; state_in = S_WAIT;
         end
         S_Q6: begin
            cmd.op = qfc_pkg::OP_ADDM; cmd.dst = qfc_pkg::R_A; cmd.src = qfc_pkg::R_T1;
            state_in = S_QNX;
         end
         S_QNX: begin
            cmd.op = qfc_pkg::OP_RDEC;
            state_in = S_Q1;
         end
         S_WAIT: begin
            if (stat.mul_done) begin
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         pass_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         pass_ff  <= pass_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      verd_ff <= verd_in;
      step_ff <= step_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rv_ff;
   assign rsp_verdict     = verd_ff;
   assign rsp_failed_step = step_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_IDLE)
      else $error("result strobe while sequencer still running");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_pass_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_verdict) |-> rsp_failed_step == qfc_pkg::STEP_NONE)
      else $error("probable prime reported with a failing step");

   a_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> state_ff == S_CHK)
      else $error("accepted request did not start the check");

endmodule

/* hdl/quadratic_frobenius_core.sv */
// top level of the quadratic frobenius core: steps three to five of the test
// depends on qfc_pkg, qfc_ctrl, qfc_datapath (which holds qfc_mul)
//
// channel   | ports                                              | handshake
// request   | req_modulus, req_param_b, req_param_c,             | start & !busy
//           | req_discriminant                                   |
// result    | rsp_verdict, rsp_failed_step                       | rsp_valid, one cycle
//
// one request at a time; busy stays high from the accept until the result strobe
// every modular multiply is bit serial, working on one multiplier bit at a time
// an exponent bit costs 3 multiplies, 7 when the bit is one; step 5 squarings cost 5 each, or 1 while bj is zero
// step 3 runs a W-bit chain; the 2W-bit value n*n - 1 splits into the s chain and squarings
// a bad modulus (even, or 1) fails from the check state, before any multiply
// reset is synchronous, active high, and returns the sequencer to idle
// the receiver cannot stall: the result is shown for exactly one cycle
module quadratic_frobenius_core #(
   parameter int MOD_WIDTH = qfc_pkg::MOD_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_modulus,
   input  logic [31:0] req_param_b,
   input  logic [31:0] req_param_c,
   input  logic [31:0] req_discriminant,
   output logic        rsp_valid,
   output logic        rsp_verdict,
   output logic [1:0]  rsp_failed_step
);
   qfc_pkg::cmd_type  cmd;
   qfc_pkg::stat_type stat;

   // only the low MOD_WIDTH bits of each operand take part
   qfc_datapath #(.W(MOD_WIDTH)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .in_modulus      (req_modulus[MOD_WIDTH-1:0]),
      .in_param_b      (req_param_b[MOD_WIDTH-1:0]),
      .in_param_c      (req_param_c[MOD_WIDTH-1:0]),
      .in_discriminant (req_discriminant[MOD_WIDTH-1:0]),
      .stat            (stat)
   );

   // sequencer: reduction, two exponent chains, then the square chain
   qfc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .stat            (stat),
      .cmd             (cmd),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_verdict     (rsp_verdict),
      .rsp_failed_step (rsp_failed_step)
   );

endmodule
